// ----- design/json_byte_stream_tokenizer_defines.svh -----
// Assertion macros shared by the checker.
`ifndef JSON_BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define JSON_BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define JBT_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define JBT_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ----- design/jbt_pkg.sv -----
`timescale 1ns / 1ps
package jbt_pkg;
    localparam int PosW = 32;
    localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
    localparam logic [PosW-1:0] PosOne = PosW'(1);

    localparam logic [3:0] K_EOF = 4'd0;
    localparam logic [3:0] K_ERR = 4'd1;
    localparam logic [3:0] K_NULL = 4'd2;
    localparam logic [3:0] K_STR = 4'd5;
    localparam logic [3:0] K_ESTR = 4'd6;
    localparam logic [3:0] K_INT = 4'd7;
    localparam logic [3:0] K_FLT = 4'd8;
    localparam logic [3:0] K_LBRK = 4'd9;
    localparam logic [3:0] K_RBRK = 4'd10;
    localparam logic [3:0] K_LBRC = 4'd11;
    localparam logic [3:0] K_RBRC = 4'd12;
    localparam logic [3:0] K_COLON = 4'd13;
    localparam logic [3:0] K_COMMA = 4'd14;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_KW = 3'd1;
    localparam logic [2:0] E_CTRL = 3'd2;
    localparam logic [2:0] E_UNTERM = 3'd3;
    localparam logic [2:0] E_UNKNOWN = 3'd4;

    localparam logic [7:0] CtrlLimit = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_begin;
        logic [31:0] token_end;
        logic [31:0] token_line;
        logic [31:0] token_column;
        logic [2:0]  error_code;
        logic [7:0]  error_byte;
        logic        last_in_run;
    } t_out;

    // Up to three results of one item.
    typedef struct packed {
        logic [1:0] count;
        t_out [2:0] res;
    } t_bundle;

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_KW   = 5'b00010,
        M_STR  = 5'b00100,
        M_ESC  = 5'b01000,
        M_NUM  = 5'b10000
    } t_mode;

    function automatic logic [PosW-1:0] sat_inc(input logic [PosW-1:0] v);
        return (v == PosMax) ? v : v + 1'b1;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] s, input logic [2:0] i);
        logic [7:0] c;
        c = 8'd0;
        case (s)
            2'd0: begin
                case (i)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'd0;
                endcase
            end
            2'd1: begin
                case (i)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'd0;
                endcase
            end
            default: begin
                case (i)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'd0;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [31:0] lo32(input logic [PosW-1:0] v);
        return v[31:0];
    endfunction
endpackage

// ----- design/jbt_front.sv -----
`timescale 1ns / 1ps
module jbt_front
    import jbt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_in     i_item,
    output logic    o_push,
    output t_bundle o_bundle,
    input  logic    i_full
);
    t_mode             r_mode, n_mode;
    logic [1:0]        r_sel, n_sel;
    logic [2:0]        r_matched, n_matched;
    logic [PosW-1:0]   r_soff, n_soff, r_sline, n_sline, r_scol, n_scol;
    logic              r_esc, n_esc, r_flt, n_flt;
    logic [PosW-1:0]   r_off, n_off, r_line, n_line, r_col, n_col;
    logic              r_cr, n_cr, r_stuck, n_stuck;
    t_bundle           bnd;
    logic              take;
    logic [7:0]        b;

    assign o_stall = i_full;
    assign take = i_valid && !i_full;
    assign b = i_item.data_byte;

    always_comb begin
        logic [2:0]  klen;
        logic        idle_lex, punc_hit, vend, numb, fmark;
        logic [3:0]  pk;
        n_mode = r_mode; n_sel = r_sel; n_matched = r_matched;
        n_soff = r_soff; n_sline = r_sline; n_scol = r_scol;
        n_esc = r_esc; n_flt = r_flt; n_off = r_off; n_line = r_line; n_col = r_col;
        n_cr = r_cr; n_stuck = r_stuck;
        bnd = '0;
        idle_lex = 1'b0;
        punc_hit = 1'b0;
        pk = K_EOF;
        klen = (r_sel[1]) ? 3'd5 : 3'd4;
        vend = (b == " ") || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a) ||
               (b == ",") || (b == "]") || (b == "}");
        fmark = (b == ".") || (b == "e") || (b == "E");
        numb = (b >= "0" && b <= "9") || fmark || (b == "+") || (b == "-");
        if (!r_stuck && i_item.has_byte) begin
            if (r_cr && b == 8'h0a) begin
                n_cr = 1'b0;
                n_off = sat_inc(r_off);
            end else begin
                n_cr = 1'b0;
                case (r_mode)
                    M_KW: begin
                        if (r_matched < klen) begin
                            if (b == kw_char(r_sel, r_matched)) begin
                                n_matched = r_matched + 3'd1;
                                n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                            end else begin
                                bnd.res[0] = '{K_ERR, lo32(r_soff), lo32(r_soff),
                                    lo32(r_sline), lo32(r_scol), E_KW, 8'd0, 1'b0};
                                bnd.count = 2'd1; n_stuck = 1'b1;
                            end
                        end else if (vend) begin
                            bnd.res[0] = '{K_NULL + {2'b00, (r_sel == 2'd0) ? 2'd0 :
                                (r_sel == 2'd1) ? 2'd1 : 2'd2}, lo32(r_soff), lo32(r_off),
                                lo32(r_sline), lo32(r_scol), E_NONE, 8'd0, 1'b0};
                            bnd.count = 2'd1; idle_lex = 1'b1;
                        end else begin
                            bnd.res[0] = '{K_ERR, lo32(r_off), lo32(r_off), lo32(r_line),
                                lo32(r_col), E_KW, b, 1'b0};
                            bnd.count = 2'd1; n_stuck = 1'b1;
                        end
                    end
                    M_STR: begin
                        if (b == 8'h22) begin
                            n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                            bnd.res[0] = '{r_esc ? K_ESTR : K_STR, lo32(r_soff),
                                lo32(sat_inc(r_off)), lo32(r_sline), lo32(r_scol),
                                E_NONE, 8'd0, 1'b0};
                            bnd.count = 2'd1; n_mode = M_IDLE;
                        end else if (b < CtrlLimit) begin
                            bnd.res[0] = '{K_ERR, lo32(r_off), lo32(r_off), lo32(r_line),
                                lo32(r_col), E_CTRL, b, 1'b0};
                            bnd.count = 2'd1; n_stuck = 1'b1;
                        end else begin
                            if (b == 8'h5c) begin
                                n_esc = 1'b1; n_mode = M_ESC;
                            end
                            n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                        end
                    end
                    M_ESC: begin
                        n_off = sat_inc(r_off);
                        if (b == 8'h0d || b == 8'h0a) begin
                            n_line = sat_inc(r_line); n_col = PosOne;
                            n_cr = (b == 8'h0d);
                        end else begin
                            n_col = sat_inc(r_col);
                        end
                        n_mode = M_STR;
                    end
                    M_NUM: begin
                        if (numb) begin
                            if (fmark) n_flt = 1'b1;
                            n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                        end else begin
                            bnd.res[0] = '{r_flt ? K_FLT : K_INT, lo32(r_soff), lo32(r_off),
                                lo32(r_sline), lo32(r_scol), E_NONE, 8'd0, 1'b0};
                            bnd.count = 2'd1; idle_lex = 1'b1;
                        end
                    end
                    default: idle_lex = 1'b1;
                endcase
            end
            if (idle_lex) begin
                n_mode = M_IDLE;
                punc_hit = 1'b1;
                pk = K_EOF;
                case (b)
                    "[": pk = K_LBRK;
                    "]": pk = K_RBRK;
                    "{": pk = K_LBRC;
                    "}": pk = K_RBRC;
                    ":": pk = K_COLON;
                    ",": pk = K_COMMA;
                    default: punc_hit = 1'b0;
                endcase
                if (b == " " || b == 8'h09) begin
                    n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                end else if (b == 8'h0d || b == 8'h0a) begin
                    n_off = sat_inc(r_off); n_line = sat_inc(r_line); n_col = PosOne;
                    n_cr = (b == 8'h0d);
                end else if (b == "n" || b == "t" || b == "f") begin
                    n_sel = (b == "n") ? 2'd0 : (b == "t") ? 2'd1 : 2'd2;
                    n_matched = 3'd1;
                    n_soff = r_off; n_sline = r_line; n_scol = r_col;
                    n_mode = M_KW;
                    n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                end else if (b == 8'h22) begin
                    n_soff = r_off; n_sline = r_line; n_scol = r_col;
                    n_esc = 1'b0; n_mode = M_STR;
                    n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                end else if (punc_hit) begin
                    bnd.res[bnd.count] = '{pk, lo32(r_off), lo32(sat_inc(r_off)),
                        lo32(r_line), lo32(r_col), E_NONE, 8'd0, 1'b0};
                    bnd.count = bnd.count + 2'd1;
                    n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                end else if (b == "-" || (b >= "0" && b <= "9")) begin
                    n_soff = r_off; n_sline = r_line; n_scol = r_col;
                    n_flt = 1'b0; n_mode = M_NUM;
                    n_off = sat_inc(r_off); n_col = sat_inc(r_col);
                end else begin
                    bnd.res[bnd.count] = '{K_ERR, lo32(r_off), lo32(r_off), lo32(r_line),
                        lo32(r_col),
                        ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) ? E_KW : E_UNKNOWN,
                        ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) ? 8'd0 : b, 1'b0};
                    bnd.count = bnd.count + 2'd1; n_stuck = 1'b1;
                end
            end
        end
        if (i_item.end_of_input) begin
            if (!n_stuck) begin
                case (n_mode)
                    M_KW: begin
                        if (n_matched >= ((n_sel[1]) ? 3'd5 : 3'd4)) begin
                            bnd.res[bnd.count] = '{K_NULL + {2'b00, (n_sel == 2'd0) ? 2'd0 :
                                (n_sel == 2'd1) ? 2'd1 : 2'd2}, lo32(n_soff), lo32(n_off),
                                lo32(n_sline), lo32(n_scol), E_NONE, 8'd0, 1'b0};
                        end else begin
                            bnd.res[bnd.count] = '{K_ERR, lo32(n_soff), lo32(n_soff),
                                lo32(n_sline), lo32(n_scol), E_KW, 8'd0, 1'b0};
                            n_stuck = 1'b1;
                        end
                        bnd.count = bnd.count + 2'd1;
                    end
                    M_STR, M_ESC: begin
                        bnd.res[bnd.count] = '{K_ERR, lo32(n_off), lo32(n_off),
                            lo32(n_line), lo32(n_col), E_UNTERM, 8'd0, 1'b0};
                        bnd.count = bnd.count + 2'd1; n_stuck = 1'b1;
                    end
                    M_NUM: begin
                        bnd.res[bnd.count] = '{n_flt ? K_FLT : K_INT, lo32(n_soff),
                            lo32(n_off), lo32(n_sline), lo32(n_scol), E_NONE, 8'd0, 1'b0};
                        bnd.count = bnd.count + 2'd1;
                    end
                    default: ;
                endcase
                if (!n_stuck) begin
                    bnd.res[bnd.count] = '{K_EOF, lo32(n_off), lo32(n_off), lo32(n_line),
                        lo32(n_col), E_NONE, 8'd0, 1'b0};
                    bnd.count = bnd.count + 2'd1;
                end
            end
            n_mode = M_IDLE; n_sel = '0; n_matched = '0;
            n_soff = '0; n_sline = PosOne; n_scol = PosOne; n_esc = 1'b0; n_flt = 1'b0;
            n_off = '0; n_line = PosOne; n_col = PosOne; n_cr = 1'b0; n_stuck = 1'b0;
        end
        if (bnd.count != 2'd0) bnd.res[bnd.count - 2'd1].last_in_run = 1'b1;
    end

    assign o_push = take && (bnd.count != 2'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_sel <= '0; r_matched <= '0;
            r_soff <= '0; r_sline <= PosOne; r_scol <= PosOne; r_esc <= 1'b0; r_flt <= 1'b0;
            r_off <= '0; r_line <= PosOne; r_col <= PosOne; r_cr <= 1'b0; r_stuck <= 1'b0;
        end else if (take) begin
            r_mode <= n_mode; r_sel <= n_sel; r_matched <= n_matched;
            r_soff <= n_soff; r_sline <= n_sline; r_scol <= n_scol;
            r_esc <= n_esc; r_flt <= n_flt; r_off <= n_off; r_line <= n_line;
            r_col <= n_col; r_cr <= n_cr; r_stuck <= n_stuck;
        end
    end
endmodule

// ----- design/jbt_back.sv -----
`timescale 1ns / 1ps
module jbt_back
    import jbt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_out    o_item
);
    // Two-entry bundle queue, drained one result a cycle while i_stall is low.
    t_bundle    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       pop_res, pop_b;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item = r_q[r_rp].res[r_idx];
    assign pop_res = o_valid && !i_stall;
    assign pop_b = pop_res && (r_idx == r_q[r_rp].count - 2'd1);

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_idx <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop_b) begin
                r_rp <= ~r_rp; r_idx <= '0;
            end else if (pop_res) begin
                r_idx <= r_idx + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop_b};
        end
    end
endmodule

// ----- design/json_byte_stream_tokenizer.sv -----
`timescale 1ns / 1ps
// JSON tokenizer: one byte item is taken per cycle while the two-entry bundle queue has room;
// each item yields zero to three tokens, leaving one token per cycle unless i_stall holds them, so
// sustained rate is one item per cycle when items average at most one token, set by the output drain.
module json_byte_stream_tokenizer
    import jbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    logic    push, full;
    t_bundle bnd;

    jbt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(i_data),
        .o_push(push), .o_bundle(bnd), .i_full(full)
    );

    jbt_back u_back (
        .i_clk, .i_rst_n, .i_push(push), .i_bundle(bnd), .o_full(full),
        .o_valid, .i_stall, .o_item(o_data)
    );
endmodule

// ----- design/jbt_checker.sv -----
`timescale 1ns / 1ps
`include "json_byte_stream_tokenizer_defines.svh"
module jbt_checker
    import jbt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);
    `JBT_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_data), "stalled input changed")
    `JBT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "stalled output changed")
    `JBT_ASSERT_IMP(a_err_code, i_clk, i_rst_n, o_valid && o_data.token_kind != K_ERR, o_data.error_code == E_NONE, "code on non-error")
    `JBT_ASSERT_IMP(a_err_pos, i_clk, i_rst_n, o_valid && o_data.token_kind == K_ERR, o_data.token_begin == o_data.token_end, "error span")
    `JBT_ASSERT_IMP(a_line, i_clk, i_rst_n, o_valid, o_data.token_line != 32'd0, "line zero")
endmodule

bind json_byte_stream_tokenizer jbt_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data
);

// ----- tb/json_byte_stream_tokenizer_tb.sv -----
`timescale 1ns / 1ps
module json_byte_stream_tokenizer_tb;
    import jbt_pkg::*;

    localparam logic [2:0] SCAN_IDLE = 3'd0;
    localparam logic [2:0] SCAN_KEYWORD = 3'd1;
    localparam logic [2:0] SCAN_STRING = 3'd2;
    localparam logic [2:0] SCAN_ESCAPE = 3'd3;
    localparam logic [2:0] SCAN_NUMBER = 3'd4;
    localparam logic [3:0] KIND_TRUE = 4'd3;
    localparam logic [3:0] KIND_FALSE = 4'd4;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    json_byte_stream_tokenizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    t_out expected_tokens[$];
    int mismatches;
    bit hold_off;
    bit no_gaps;

    logic [2:0] lx_mode;
    logic [1:0] lx_sel;
    logic [2:0] lx_matched;
    logic [31:0] lx_start_off, lx_start_line, lx_start_col;
    logic lx_esc, lx_float;
    logic [31:0] lx_off, lx_line, lx_col;
    logic lx_prev_cr, lx_stuck;
    t_out tok_buf[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [7:0] keyword_letter(input logic [1:0] s, input logic [2:0] i);
        string w;
        w = (s == 2'd0) ? "null" : (s == 2'd1) ? "true" : "false";
        return (i < w.len()) ? w[i] : 8'd0;
    endfunction

    function automatic logic [2:0] keyword_length(input logic [1:0] s);
        return (s < 2'd2) ? 3'd4 : 3'd5;
    endfunction

    function automatic logic [3:0] keyword_kind(input logic [1:0] s);
        return (s == 2'd0) ? K_NULL : (s == 2'd1) ? KIND_TRUE : KIND_FALSE;
    endfunction

    function automatic bit ends_value(input logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A || b == "," || b == "]"
            || b == "}";
    endfunction

    function automatic bit float_mark(input logic [7:0] b);
        return b == "." || b == "e" || b == "E";
    endfunction

    task automatic push_token(input logic [3:0] k, input logic [31:0] b, input logic [31:0] e,
                              input logic [31:0] l, input logic [31:0] c,
                              input logic [2:0] code, input logic [7:0] eb);
        t_out t;
        t = '{token_kind: k, token_begin: b, token_end: e, token_line: l, token_column: c,
              error_code: code, error_byte: eb, last_in_run: 1'b0};
        tok_buf.push_back(t);
    endtask

    task automatic advance_column();
        lx_off = inc32(lx_off);
        lx_col = inc32(lx_col);
    endtask

    task automatic advance_line();
        lx_off = inc32(lx_off);
        lx_line = inc32(lx_line);
        lx_col = 32'd1;
    endtask

    task automatic error_here(input logic [2:0] code, input logic [7:0] eb);
        push_token(K_ERR, lx_off, lx_off, lx_line, lx_col, code, eb);
        lx_stuck = 1'b1;
    endtask

    task automatic error_at_start();
        push_token(K_ERR, lx_start_off, lx_start_off, lx_start_line, lx_start_col, E_KW, 8'd0);
        lx_stuck = 1'b1;
    endtask

    task automatic note_start();
        lx_start_off = lx_off;
        lx_start_line = lx_line;
        lx_start_col = lx_col;
    endtask

    task automatic lexer_reset();
        lx_mode = SCAN_IDLE;
        lx_sel = 2'd0;
        lx_matched = 3'd0;
        lx_start_off = 32'd0;
        lx_start_line = 32'd1;
        lx_start_col = 32'd1;
        lx_esc = 1'b0;
        lx_float = 1'b0;
        lx_off = 32'd0;
        lx_line = 32'd1;
        lx_col = 32'd1;
        lx_prev_cr = 1'b0;
        lx_stuck = 1'b0;
    endtask

    task automatic lex_between(input logic [7:0] b);
        logic [3:0] punc;
        punc = K_EOF;
        lx_mode = SCAN_IDLE;
        case (b)
            " ", 8'h09: advance_column();
            8'h0D: begin
                advance_line();
                lx_prev_cr = 1'b1;
            end
            8'h0A: advance_line();
            "n", "t", "f": begin
                lx_sel = (b == "n") ? 2'd0 : (b == "t") ? 2'd1 : 2'd2;
                lx_matched = 3'd1;
                note_start();
                lx_mode = SCAN_KEYWORD;
                advance_column();
            end
            "\"": begin
                note_start();
                lx_esc = 1'b0;
                lx_mode = SCAN_STRING;
                advance_column();
            end
            "[": punc = K_LBRK;
            "]": punc = K_RBRK;
            "{": punc = K_LBRC;
            "}": punc = K_RBRC;
            ":": punc = K_COLON;
            ",": punc = K_COMMA;
            default: begin
                if (b == "-" || (b >= "0" && b <= "9")) begin
                    note_start();
                    lx_float = 1'b0;
                    lx_mode = SCAN_NUMBER;
                    advance_column();
                end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
                    error_here(E_KW, 8'd0);
                end else begin
                    error_here(E_UNKNOWN, b);
                end
            end
        endcase
        if (punc != K_EOF) begin
            push_token(punc, lx_off, inc32(lx_off), lx_line, lx_col, E_NONE, 8'd0);
            advance_column();
        end
    endtask

    task automatic lex_one(input logic [7:0] b);
        if (lx_prev_cr && b == 8'h0A) begin
            lx_prev_cr = 1'b0;
            lx_off = inc32(lx_off);
            return;
        end
        lx_prev_cr = 1'b0;
        case (lx_mode)
            SCAN_KEYWORD: begin
                if (lx_matched < keyword_length(lx_sel)) begin
                    if (b == keyword_letter(lx_sel, lx_matched)) begin
                        lx_matched++;
                        advance_column();
                    end else begin
                        error_at_start();
                    end
                end else if (ends_value(b)) begin
                    push_token(keyword_kind(lx_sel), lx_start_off, lx_off, lx_start_line,
                               lx_start_col, E_NONE, 8'd0);
                    lex_between(b);
                end else begin
                    error_here(E_KW, b);
                end
            end
            SCAN_STRING: begin
                if (b == "\"") begin
                    advance_column();
                    push_token(lx_esc ? K_ESTR : K_STR, lx_start_off, lx_off, lx_start_line,
                               lx_start_col, E_NONE, 8'd0);
                    lx_mode = SCAN_IDLE;
                end else if (b < CtrlLimit) begin
                    error_here(E_CTRL, b);
                end else begin
                    if (b == "\\") begin
                        lx_esc = 1'b1;
                        lx_mode = SCAN_ESCAPE;
                    end
                    advance_column();
                end
            end
            SCAN_ESCAPE: begin
                if (b == 8'h0D) begin
                    advance_line();
                    lx_prev_cr = 1'b1;
                end else if (b == 8'h0A) begin
                    advance_line();
                end else begin
                    advance_column();
                end
                lx_mode = SCAN_STRING;
            end
            SCAN_NUMBER: begin
                if ((b >= "0" && b <= "9") || float_mark(b) || b == "+" || b == "-") begin
                    if (float_mark(b)) lx_float = 1'b1;
                    advance_column();
                end else begin
                    push_token(lx_float ? K_FLT : K_INT, lx_start_off, lx_off, lx_start_line,
                               lx_start_col, E_NONE, 8'd0);
                    lex_between(b);
                end
            end
            default: lex_between(b);
        endcase
    endtask

    task automatic close_document();
        case (lx_mode)
            SCAN_KEYWORD: begin
                if (lx_matched >= keyword_length(lx_sel)) begin
                    push_token(keyword_kind(lx_sel), lx_start_off, lx_off, lx_start_line,
                               lx_start_col, E_NONE, 8'd0);
                end else begin
                    error_at_start();
                end
            end
            SCAN_STRING, SCAN_ESCAPE: error_here(E_UNTERM, 8'd0);
            SCAN_NUMBER: push_token(lx_float ? K_FLT : K_INT, lx_start_off, lx_off,
                                    lx_start_line, lx_start_col, E_NONE, 8'd0);
            default: ;
        endcase
        if (!lx_stuck) push_token(K_EOF, lx_off, lx_off, lx_line, lx_col, E_NONE, 8'd0);
    endtask

    task automatic predict_tokens(input t_in it);
        tok_buf.delete();
        if (!lx_stuck && it.has_byte) lex_one(it.data_byte);
        if (it.end_of_input) begin
            if (!lx_stuck) close_document();
            lexer_reset();
        end
        if (tok_buf.size() > 0) tok_buf[tok_buf.size() - 1].last_in_run = 1'b1;
        foreach (tok_buf[i]) expected_tokens.push_back(tok_buf[i]);
    endtask

    task automatic send_item(input logic [7:0] b, input bit has, input bit fin);
        t_in it;
        int gap;
        it = '{data_byte: b, has_byte: has, end_of_input: fin};
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            i_data <= t_in'(10'($urandom));
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        predict_tokens(it);
    endtask

    task automatic send_text(input string s, input bit fin);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, fin && (i == s.len() - 1));
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected token %p", o_data);
            end else begin
                e = expected_tokens.pop_front();
                if (o_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Token mismatch: expected %p actual %p", e,
                                                   o_data);
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
            end else if (no_gaps) begin
                i_stall <= 1'b0;
            end else begin
                gap = $urandom_range(0, 7);
                if (gap != 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    task automatic test_directed();
        send_text("{\"a\":[null,true,false],\"b\\\"\":-12.5e+3}", 1'b1);
        send_text(" 42\r\n7\r8\n\"x\\\ny\"", 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_text("nul", 1'b1);
        send_text("truex", 1'b1);
        send_text("xyz", 1'b1);
        send_text("\"ab", 1'b1);
        send_text("\"a", 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_text("true]", 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_documents();
        string pieces[] = '{"null", "true", "false", "\"s\"", "\"e\\\\q\"", "-3", "1.5E-2",
                            "[", "]", "{", "}", ":", ",", " ", "\t", "\r\n", "\n", "\r",
                            "nulx", "\"\\\r\"", "0"};
        int sent;
        int k;
        sent = 0;
        while (sent < 240) begin
            k = $urandom_range(1, 8);
            repeat (k) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(8'($urandom), 1'b1, 1'b0);
                    sent++;
                end else begin
                    string p;
                    p = pieces[$urandom_range(0, pieces.size() - 1)];
                    send_text(p, 1'b0);
                    sent += p.len();
                end
            end
            if ($urandom_range(0, 1)) send_item(8'($urandom), 1'b1, 1'b1);
            else send_item(8'($urandom), 1'b0, 1'b1);
            sent++;
        end
        i_valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                no_gaps = 1'b1;
                send_text("[1,2,3,4,5,6,7,8,9,0,1,2]", 1'b1);
                i_valid <= 1'b0;
                no_gaps = 1'b0;
            end
        join
    endtask

    initial begin
        int guard;
        mismatches = 0;
        hold_off = 1'b0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        lexer_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_documents();
        guard = 0;
        while (expected_tokens.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/jbt_pkg.sv
design/jbt_front.sv
design/jbt_back.sv
design/json_byte_stream_tokenizer.sv
design/jbt_checker.sv
tb/json_byte_stream_tokenizer_tb.sv
